// ----- hdl/pow_tc_pkg.sv -----
// Shared widths, status codes, exponent thresholds and limit reset values for the compact target checker.
// Depends on nothing; imported by proof_of_work_target_check_unit, pow_tc_checker and testbench.
package pow_tc_pkg;

    // Payload widths.
    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = 4;
    localparam int VAL_W      = WORD_W * NUM_WORDS;
    localparam int COMPACT_W  = 32;
    localparam int MANT_W     = 23;
    localparam int EXPO_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = VAL_W + COMPACT_W;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABOVE_LIM = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HASH_HIGH = 3'd5;

    // Exponent thresholds used by the expansion and overflow rules.
    localparam logic [EXPO_W-1:0] EXPO_MAX_SMALL = 8'd3;
    localparam logic [EXPO_W-1:0] EXPO_LIM_ANY   = 8'd34;
    localparam logic [EXPO_W-1:0] EXPO_LIM_BYTE  = 8'd33;
    localparam logic [EXPO_W-1:0] EXPO_LIM_HALF  = 8'd32;

    // Reset value of the limit words, word 0 least significant.
    localparam logic [WORD_W-1:0] LIMIT_RST_LOW = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] LIMIT_RST_TOP = 64'h0000_0000_FFFF_FFFF;

endpackage

// ----- hdl/proof_of_work_target_check_unit.sv -----
// Top level of the compact target checker: expands a 32-bit compact target and
// checks a 256-bit hash against it. Depends on pow_tc_pkg.
//
// Usage:
//   Input stream (s_axis_*): one transfer carries a 256-bit hash and a 32-bit
//   compact target word. Output stream (m_axis_*): one transfer per input item
//   with the pass flag and a 3-bit status code, in input order.
//   Configuration: i_cfg_we writes i_cfg_data into limit word i_cfg_index at
//   the clock edge; the four words form the 256-bit highest allowed target.
//   Write it only while no items are in flight.
//   Throughput is one item per cycle when not stalled; the pipeline is three
//   register stages: target expansion, per-word compares, and status
//   resolution into the output register.
//   When the receiver stalls, the whole pipeline holds and s_axis_tready falls
//   once the output register is full; nothing is dropped or repeated.
//   Reset (synchronous, active low) empties the pipeline and loads the limit
//   with its default value; results in flight are discarded.
module proof_of_work_target_check_unit
    import pow_tc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: hash_word0[63:0], hash_word1[127:64], hash_word2[191:128],
    //        hash_word3[255:192], compact_target[287:256]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: pass[0], status[3:1], zero fill[7:4]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data
);

    // Pipeline advance: the whole pipe moves when the output register is free.
    logic w_adv;
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // Limit registers.
    logic [WORD_W-1:0] r_limit [NUM_WORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit[0] <= LIMIT_RST_LOW;
            r_limit[1] <= LIMIT_RST_LOW;
            r_limit[2] <= LIMIT_RST_LOW;
            r_limit[3] <= LIMIT_RST_TOP;
        end else if (i_cfg_we) begin
            r_limit[i_cfg_index] <= i_cfg_data;
        end
    end

    // Stage 1: decode the compact word and expand the target.
    logic [COMPACT_W-1:0] w_compact;
    logic [EXPO_W-1:0]    w_expo;
    logic [4:0]           w_expo_m3;
    logic [MANT_W-1:0]    w_mant_raw;
    logic [MANT_W-1:0]    w_mant;
    logic [1:0]           w_small_sh;
    logic                 w_small;
    logic [VAL_W-1:0]     w_target;
    logic                 w_neg;
    logic                 w_ovf;
    logic                 w_mant_nz;

    always_comb begin
        w_compact  = s_axis_tdata[IN_DATA_W-1:VAL_W];
        w_expo     = w_compact[COMPACT_W-1:COMPACT_W-EXPO_W];
        w_mant_raw = w_compact[MANT_W-1:0];
        w_small    = (w_expo <= EXPO_MAX_SMALL);
        w_small_sh = 2'd3 - w_expo[1:0];
        // Byte count of the left shift; only exponents 4 to 34 use it.
        w_expo_m3  = w_expo[4:0] - EXPO_MAX_SMALL[4:0];
        w_mant     = w_small ? (w_mant_raw >> {w_small_sh, 3'b000}) : w_mant_raw;
        w_mant_nz  = |w_mant;

        // Byte shift of the mantissa; shifts past bit 255 leave zero.
        if (w_small) begin
            w_target = {{(VAL_W-MANT_W){1'b0}}, w_mant};
        end else if (w_expo <= EXPO_LIM_ANY) begin
            w_target = {{(VAL_W-MANT_W){1'b0}}, w_mant} << {w_expo_m3, 3'b000};
        end else begin
            w_target = '0;
        end

        w_neg = w_mant_nz && w_compact[MANT_W];
        w_ovf = w_mant_nz && ((w_expo > EXPO_LIM_ANY) ||
                              ((w_mant > 23'h0000FF) && (w_expo > EXPO_LIM_BYTE)) ||
                              ((w_mant > 23'h00FFFF) && (w_expo > EXPO_LIM_HALF)));
    end

    logic             r_v1;
    logic [VAL_W-1:0] r_target1;
    logic [VAL_W-1:0] r_hash1;
    logic             r_neg1;
    logic             r_ovf1;

    // Stage 2: per-word compares of target against limit and hash against target.
    logic [NUM_WORDS-1:0] w_tl_gt;
    logic [NUM_WORDS-1:0] w_tl_eq;
    logic [NUM_WORDS-1:0] w_ht_gt;
    logic [NUM_WORDS-1:0] w_ht_eq;

    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            w_tl_gt[i] = r_target1[i*WORD_W +: WORD_W] > r_limit[i];
            w_tl_eq[i] = r_target1[i*WORD_W +: WORD_W] == r_limit[i];
            w_ht_gt[i] = r_hash1[i*WORD_W +: WORD_W] > r_target1[i*WORD_W +: WORD_W];
            w_ht_eq[i] = r_hash1[i*WORD_W +: WORD_W] == r_target1[i*WORD_W +: WORD_W];
        end
    end

    logic                 r_v2;
    logic                 r_neg2;
    logic                 r_ovf2;
    logic                 r_zero2;
    logic [NUM_WORDS-1:0] r_tl_gt2;
    logic [NUM_WORDS-1:0] r_tl_eq2;
    logic [NUM_WORDS-1:0] r_ht_gt2;
    logic [NUM_WORDS-1:0] r_ht_eq2;

    // Stage 3: merge word compares from the least significant word up, then
    // pick the first rejection in priority order.
    logic                w_above;
    logic                w_hash_high;
    logic [STATUS_W-1:0] n_status;

    always_comb begin
        w_above     = 1'b0;
        w_hash_high = 1'b0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            w_above     = r_tl_gt2[i] || (r_tl_eq2[i] && w_above);
            w_hash_high = r_ht_gt2[i] || (r_ht_eq2[i] && w_hash_high);
        end
        priority if (r_neg2) begin
            n_status = ST_NEGATIVE;
        end else if (r_zero2) begin
            n_status = ST_ZERO;
        end else if (r_ovf2) begin
            n_status = ST_OVERFLOW;
        end else if (w_above) begin
            n_status = ST_ABOVE_LIM;
        end else if (w_hash_high) begin
            n_status = ST_HASH_HIGH;
        end else begin
            n_status = ST_OK;
        end
    end

    logic                r_v3;
    logic [STATUS_W-1:0] r_status;

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_target1 <= w_target;
            r_hash1   <= s_axis_tdata[VAL_W-1:0];
            r_neg1    <= w_neg;
            r_ovf1    <= w_ovf;

            r_neg2    <= r_neg1;
            r_ovf2    <= r_ovf1;
            r_zero2   <= ~|r_target1;
            r_tl_gt2  <= w_tl_gt;
            r_tl_eq2  <= w_tl_eq;
            r_ht_gt2  <= w_ht_gt;
            r_ht_eq2  <= w_ht_eq;

            r_status  <= n_status;
        end
    end

    // Output stream.
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{(OUT_DATA_W-STATUS_W-1){1'b0}}, r_status, (r_status == ST_OK)};

    // The pass flag agrees with an ok status.
    a_pass_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == ST_OK)))
        else $error("pass flag disagrees with status");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:1] <= ST_HASH_HIGH))
        else $error("status code out of range");

    // An accepted item reaches the output register once the pipeline has advanced it through each stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 w_adv ##1 w_adv |=> m_axis_tvalid)
        else $error("accepted item lost in the pipeline");

    // A negative target always wins the priority.
    a_neg_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_neg2 && w_adv) |=> (r_status == ST_NEGATIVE))
        else $error("negative target not reported first");

endmodule

// ----- dv/pow_tc_checker.sv -----
`timescale 1ns / 100ps
// Checker for the compact target checker: watches both streams and the limit write port,
// predicts each verdict and compares it with the output stream. Depends on pow_tc_pkg.
module pow_tc_checker
    import pow_tc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_tvalid,
    input  logic                  i_in_tready,
    // tdata: hash_word0..hash_word3 [255:0], compact_target [287:256]
    input  logic [IN_DATA_W-1:0]  i_in_tdata,
    input  logic                  i_out_tvalid,
    input  logic                  i_out_tready,
    // tdata: pass[0], status[3:1], zero fill[7:4]
    input  logic [OUT_DATA_W-1:0] i_out_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data,
    output int                    o_fail_count,
    output int                    o_verdicts_waiting
);

    localparam int SIGN_BIT = MANT_W;

    typedef struct packed {
        logic                pass;
        logic [STATUS_W-1:0] status;
    } t_verdict;

    logic [VAL_W-1:0] limit_copy;
    t_verdict         expected_verdicts[$];
    int               fails;

    initial begin
        fails = 0;
    end

    // Expand the compact word and rank the rejections in priority order.
    function automatic t_verdict judge_hash(input logic [VAL_W-1:0]     hash,
                                            input logic [COMPACT_W-1:0] compact,
                                            input logic [VAL_W-1:0]     ceiling);
        logic [EXPO_W-1:0] expo;
        logic [31:0]       mant;
        logic [VAL_W-1:0]  target;
        logic              negative;
        logic              too_wide;
        t_verdict          v;
        expo = compact[COMPACT_W-1 -: EXPO_W];
        mant = 32'(compact[MANT_W-1:0]);
        // Small exponents shift the mantissa right; large ones shift it left and
        // anything beyond bit 255 falls off.
        if (expo <= EXPO_MAX_SMALL) begin
            mant   = mant >> (8 * (int'(EXPO_MAX_SMALL) - int'(expo)));
            target = VAL_W'(mant);
        end else begin
            target = VAL_W'(mant) << (8 * (int'(expo) - int'(EXPO_MAX_SMALL)));
        end
        negative = (mant != 0) && compact[SIGN_BIT];
        too_wide = (mant != 0) && ((expo > EXPO_LIM_ANY) ||
                                   (mant > 32'hFF && expo > EXPO_LIM_BYTE) ||
                                   (mant > 32'hFFFF && expo > EXPO_LIM_HALF));
        if (negative)
            v.status = ST_NEGATIVE;
        else if (target == '0)
            v.status = ST_ZERO;
        else if (too_wide)
            v.status = ST_OVERFLOW;
        else if (target > ceiling)
            v.status = ST_ABOVE_LIM;
        else if (hash > target)
            v.status = ST_HASH_HIGH;
        else
            v.status = ST_OK;
        v.pass = (v.status == ST_OK);
        return v;
    endfunction

    // Track the limit, queue predictions on input transfers, check output transfers.
    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            limit_copy = {LIMIT_RST_TOP, LIMIT_RST_LOW, LIMIT_RST_LOW, LIMIT_RST_LOW};
            expected_verdicts.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got.pass   = i_out_tdata[0];
                got.status = i_out_tdata[STATUS_W:1];
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result transfer: pass %0d status %0d",
                           got.pass, got.status);
                    fails++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.pass !== want.pass) begin
                        $error("pass mismatch: expected %0d, actual %0d",
                               want.pass, got.pass);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fails++;
                    end
                end
            end
            if (i_in_tvalid && i_in_tready)
                expected_verdicts.push_back(judge_hash(i_in_tdata[VAL_W-1:0],
                                                       i_in_tdata[IN_DATA_W-1:VAL_W],
                                                       limit_copy));
            if (i_cfg_we)
                limit_copy[WORD_W*i_cfg_index +: WORD_W] = i_cfg_data;
        end
        o_fail_count       <= fails;
        o_verdicts_waiting <= expected_verdicts.size();
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the compact target checker testbench: clock, reset, hash stimulus, limit
// phases, receiver stalls and the verdict. Depends on pow_tc_pkg and pow_tc_checker.
module testbench;
    import pow_tc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam logic [VAL_W-1:0] STD_TARGET = VAL_W'(16'hFFFF) << 208;
    localparam logic [VAL_W-1:0] ALL_ONES   = '1;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKED} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [WORD_W-1:0]     i_cfg_data = '0;

    int       fail_count;
    int       verdicts_waiting;
    int       burst_left = 0;
    int       idle_cycles = 0;
    int       rx_seg_left = 0;
    t_rx_mode rx_mode = RX_OPEN;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    proof_of_work_target_check_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pow_tc_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_tvalid        (s_axis_tvalid),
        .i_in_tready        (s_axis_tready),
        .i_in_tdata         (s_axis_tdata),
        .i_out_tvalid       (m_axis_tvalid),
        .i_out_tready       (m_axis_tready),
        .i_out_tdata        (m_axis_tdata),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_verdicts_waiting (verdicts_waiting)
    );

    // Receiver backpressure: segments of free flow, coin flips, rare and heavy stalls.
    always @(posedge i_clk) begin
        if (rx_seg_left == 0) begin
            rx_mode     <= t_rx_mode'($urandom_range(0, 3));
            rx_seg_left <= $urandom_range(16, 160);
        end else begin
            rx_seg_left <= rx_seg_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) != 0);
            default:   m_axis_tready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    // Watchdog on cycles without any transfer or limit write.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] random_value();
        logic [VAL_W-1:0] v;
        for (int i = 0; i < VAL_W / 32; i++)
            v[32*i +: 32] = $urandom;
        return v;
    endfunction

    // Offer one hash for checking; opens a new burst with a random gap when due.
    task automatic offer_hash(input logic [VAL_W-1:0] hash, input logic [COMPACT_W-1:0] compact);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {compact, hash};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding verdict.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (verdicts_waiting != 0)
            @(posedge i_clk);
    endtask

    // Write all four limit words, word 0 first.
    task automatic load_limit(input logic [VAL_W-1:0] ceiling);
        for (int i = 0; i < NUM_WORDS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= ceiling[WORD_W*i +: WORD_W];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed targets with hashes placed around them, the rest raw noise.
    task automatic make_random_item(output logic [VAL_W-1:0] hash,
                                    output logic [COMPACT_W-1:0] compact);
        int               pick;
        int               expo;
        int               width;
        logic [31:0]      mant;
        logic [VAL_W-1:0] target;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            expo  = ($urandom_range(0, 99) < 85) ? $urandom_range(3, 32) : $urandom_range(0, 40);
            width = $urandom_range(1, MANT_W);
            mant  = $urandom & ((32'd1 << width) - 1);
            if (mant == 0)
                mant = 32'd1;
            compact = {8'(expo), ($urandom_range(0, 15) == 0), mant[MANT_W-1:0]};
            if (expo >= 3)
                target = VAL_W'(mant) << (8 * (expo - 3));
            else
                target = VAL_W'(mant >> (8 * (3 - expo)));
            case ($urandom_range(0, 5))
                0:       hash = target;
                1:       hash = target - 1;
                2:       hash = target + 1;
                3:       hash = target ^ (random_value() >> $urandom_range(0, 255));
                default: hash = random_value() >> $urandom_range(0, 255);
            endcase
        end else if (pick < 90) begin
            compact = $urandom;
            hash    = random_value() >> $urandom_range(0, 255);
        end else begin
            compact = $urandom;
            hash    = random_value();
        end
    endtask

    task automatic run_random(input int count);
        logic [VAL_W-1:0]     hash;
        logic [COMPACT_W-1:0] compact;
        repeat (count) begin
            make_random_item(hash, compact);
            offer_hash(hash, compact);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset limit.
        offer_hash('0, 32'h0000_0000);                 // zero target
        offer_hash(ALL_ONES, 32'h0000_0000);
        offer_hash('0, 32'h0492_3456);                 // negative
        offer_hash('0, 32'hFFFF_FFFF);                 // negative at the top exponent
        offer_hash('0, 32'h0180_3456);                 // sign bit with mantissa shifted out
        offer_hash('0, 32'h0112_3456);
        offer_hash(VAL_W'(8'h12), 32'h0112_3456);      // hash equal to target
        offer_hash(VAL_W'(8'h13), 32'h0112_3456);      // hash one above
        offer_hash('0, 32'h0200_0100);
        offer_hash('0, 32'h037F_FFFF);
        offer_hash(ALL_ONES, 32'h037F_FFFF);
        offer_hash(STD_TARGET, 32'h1D00_FFFF);
        offer_hash(STD_TARGET + 1, 32'h1D00_FFFF);
        offer_hash('0, 32'h1D01_FFFF);                 // above the reset limit
        offer_hash('0, 32'h2200_0001);
        offer_hash('0, 32'h2300_0001);                 // mantissa pushed past bit 255
        offer_hash('0, 32'h2200_0101);                 // overflow, byte rule
        offer_hash('0, 32'h2101_0001);                 // overflow, half-word rule
        offer_hash('0, 32'h207F_FFFF);
        offer_hash('0, 32'h2001_0000);
        offer_hash('0, 32'hFF7F_FFFF);                 // huge exponent truncates to zero
        wait_for_idle();

        // Highest possible limit.
        load_limit(ALL_ONES);
        offer_hash(ALL_ONES, 32'h2200_0001);
        offer_hash('0, 32'h207F_FFFF);
        run_random(250);
        wait_for_idle();

        // Lowest possible limit: every valid target is above it.
        load_limit('0);
        run_random(120);
        wait_for_idle();

        // Random limit.
        load_limit(random_value() >> $urandom_range(0, 200));
        run_random(250);
        wait_for_idle();

        // Limit equal to a common target.
        load_limit(STD_TARGET);
        offer_hash('0, 32'h1D00_FFFF);                 // target equals limit
        offer_hash('0, 32'h1D01_0000);                 // just above it
        run_random(230);
        wait_for_idle();

        // Back to the reset value.
        load_limit({LIMIT_RST_TOP, LIMIT_RST_LOW, LIMIT_RST_LOW, LIMIT_RST_LOW});
        run_random(200);
        wait_for_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pow_tc_pkg.sv
hdl/proof_of_work_target_check_unit.sv
dv/pow_tc_checker.sv
dv/testbench.sv
